FILE: src/bcl_pkg.sv
`timescale 1ns / 1ps

package bcl_pkg;

   localparam int MAX_NESTING_DEF = 255;
   localparam int LINE_BITS_DEF   = 24;
   localparam int DEPTH_BITS      = 8;
   localparam int OUT_LINE_BITS   = 24;
   localparam int MAX_RESULTS     = 3;
   localparam int CNT_BITS        = 2;
   localparam int QUEUE_DEPTH     = 4;
   localparam int PTR_BITS        = $clog2(QUEUE_DEPTH);

   localparam logic [2:0] KIND_NAME_CHAR = 3'd0;
   localparam logic [2:0] KIND_OPEN      = 3'd1;
   localparam logic [2:0] KIND_DISCARD   = 3'd2;
   localparam logic [2:0] KIND_ARG_CHAR  = 3'd3;
   localparam logic [2:0] KIND_ARG_END   = 3'd4;
   localparam logic [2:0] KIND_CMD_END   = 3'd5;

   typedef struct packed {
      logic [2:0]               kind;
      logic [7:0]               ch;
      logic [OUT_LINE_BITS-1:0] line;
   } result_type;

   // all results caused by one input word
   typedef struct packed {
      logic [CNT_BITS-1:0]              count;
      result_type [MAX_RESULTS-1:0]     res;
   } bundle_type;

endpackage

FILE: src/bcl_front.sv
`timescale 1ns / 1ps

module bcl_front #(
   parameter int MAX_NESTING = bcl_pkg::MAX_NESTING_DEF,
   parameter int LINE_BITS   = bcl_pkg::LINE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          text_byte,
   input  logic                end_of_text,
   output bcl_pkg::bundle_type bundle
);
   import bcl_pkg::*;

   typedef enum logic [5:0] {
      MODE_TOP          = 6'b000001,
      MODE_TOP_COMMENT  = 6'b000010,
      MODE_NAME         = 6'b000100,
      MODE_GAP          = 6'b001000,
      MODE_LIST         = 6'b010000,
      MODE_LIST_COMMENT = 6'b100000
   } mode_type;

   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_UNDER  = 8'h5f;
   localparam logic [DEPTH_BITS-1:0] NEST_TOP = DEPTH_BITS'(MAX_NESTING);
   localparam logic [LINE_BITS-1:0]  LINE_ONE = LINE_BITS'(1);

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
   endfunction

   function automatic bundle_type add_res(input bundle_type r, input logic [2:0] k,
                                          input logic [7:0] c,
                                          input logic [OUT_LINE_BITS-1:0] l);
      bundle_type t;
      t = r;
      if (t.count != CNT_BITS'(MAX_RESULTS)) begin
         t.res[t.count].kind = k;
         t.res[t.count].ch   = c;
         t.res[t.count].line = l;
         t.count = t.count + 1'b1;
      end
      return t;
   endfunction

   mode_type               mode_ff, mode_in;
   logic                   quote_ff, quote_in;
   logic                   esc_ff, esc_in;
   logic                   arg_ff, arg_in;
   logic [DEPTH_BITS-1:0]  depth_ff, depth_in;
   logic [LINE_BITS-1:0]   cur_line_ff, cur_line_in;
   logic [LINE_BITS-1:0]   cmd_line_ff, cmd_line_in;
   bundle_type             res_v;
   logic                   redo_top, redo_gap, redo_list;
   logic [7:0]             b;

   assign b = text_byte;

   always_comb begin
      mode_in     = mode_ff;
      quote_in    = quote_ff;
      esc_in      = esc_ff;
      arg_in      = arg_ff;
      depth_in    = depth_ff;
      cur_line_in = cur_line_ff;
      cmd_line_in = cmd_line_ff;
      res_v       = '0;
      redo_top    = 1'b0;
      redo_gap    = 1'b0;
      redo_list   = 1'b0;

      case (mode_ff)
         MODE_TOP_COMMENT: begin
            if (b == CH_NL) begin
               mode_in  = MODE_TOP;
               redo_top = 1'b1;
            end
         end
         MODE_NAME: begin
            if (is_alpha(b) || is_digit(b) || b == CH_UNDER) begin
               res_v = add_res(res_v, KIND_NAME_CHAR, to_lower(b),
                               OUT_LINE_BITS'(cmd_line_in));
            end else begin
               mode_in  = MODE_GAP;
               redo_gap = 1'b1;
            end
         end
         MODE_GAP:  redo_gap = 1'b1;
         MODE_LIST: redo_list = 1'b1;
         MODE_LIST_COMMENT: begin
            if (b == CH_NL) begin
               mode_in   = MODE_LIST;
               redo_list = 1'b1;
            end
         end
         default: begin
            mode_in  = MODE_TOP;
            redo_top = 1'b1;
         end
      endcase

      // name tail: whitespace, '(' or fall back to top level
      if (redo_gap) begin
         if (is_space(b)) begin
            if (b == CH_NL && cur_line_in != '1) cur_line_in = cur_line_in + 1'b1;
         end else if (b == CH_LPAREN) begin
            res_v    = add_res(res_v, KIND_OPEN, 8'd0, OUT_LINE_BITS'(cmd_line_in));
            mode_in  = MODE_LIST;
            depth_in = DEPTH_BITS'(1);
            quote_in = 1'b0;
            esc_in   = 1'b0;
            arg_in   = 1'b0;
         end else begin
            res_v    = add_res(res_v, KIND_DISCARD, 8'd0, OUT_LINE_BITS'(cmd_line_in));
            mode_in  = MODE_TOP;
            redo_top = 1'b1;
         end
      end

      if (redo_top) begin
         if (b == CH_NL) begin
            if (cur_line_in != '1) cur_line_in = cur_line_in + 1'b1;
         end else if (b == CH_HASH) begin
            mode_in = MODE_TOP_COMMENT;
         end else if (is_alpha(b) || b == CH_UNDER) begin
            cmd_line_in = cur_line_in;
            res_v   = add_res(res_v, KIND_NAME_CHAR, to_lower(b),
                              OUT_LINE_BITS'(cmd_line_in));
            mode_in = MODE_NAME;
         end
      end

      if (redo_list) begin
         if (esc_in) begin
            esc_in = 1'b0;
            res_v  = add_res(res_v, KIND_ARG_CHAR, b, OUT_LINE_BITS'(cmd_line_in));
            arg_in = 1'b1;
         end else if (b == CH_NL) begin
            if (cur_line_in != '1) cur_line_in = cur_line_in + 1'b1;
         end else if (b == CH_HASH) begin
            mode_in = MODE_LIST_COMMENT;
         end else if (quote_in) begin
            if (b == CH_BSLASH) begin
               if (end_of_text) begin
                  res_v  = add_res(res_v, KIND_ARG_CHAR, b, OUT_LINE_BITS'(cmd_line_in));
                  arg_in = 1'b1;
               end else begin
                  esc_in = 1'b1;
               end
            end else if (b == CH_QUOTE) begin
               quote_in = 1'b0;
            end else begin
               res_v  = add_res(res_v, KIND_ARG_CHAR, b, OUT_LINE_BITS'(cmd_line_in));
               arg_in = 1'b1;
            end
         end else if (b == CH_QUOTE) begin
            quote_in = 1'b1;
         end else if (b == CH_LPAREN) begin
            if (depth_in < NEST_TOP) depth_in = depth_in + 1'b1;
            res_v  = add_res(res_v, KIND_ARG_CHAR, b, OUT_LINE_BITS'(cmd_line_in));
            arg_in = 1'b1;
         end else if (b == CH_RPAREN) begin
            if (depth_in <= DEPTH_BITS'(1)) begin
               if (arg_in)
                  res_v = add_res(res_v, KIND_ARG_END, 8'd0, OUT_LINE_BITS'(cmd_line_in));
               res_v    = add_res(res_v, KIND_CMD_END, 8'd0, OUT_LINE_BITS'(cmd_line_in));
               arg_in   = 1'b0;
               quote_in = 1'b0;
               esc_in   = 1'b0;
               depth_in = '0;
               mode_in  = MODE_TOP;
            end else begin
               depth_in = depth_in - 1'b1;
               res_v    = add_res(res_v, KIND_ARG_CHAR, b, OUT_LINE_BITS'(cmd_line_in));
               arg_in   = 1'b1;
            end
         end else if (is_space(b)) begin
            if (arg_in) begin
               res_v  = add_res(res_v, KIND_ARG_END, 8'd0, OUT_LINE_BITS'(cmd_line_in));
               arg_in = 1'b0;
            end
         end else begin
            res_v  = add_res(res_v, KIND_ARG_CHAR, b, OUT_LINE_BITS'(cmd_line_in));
            arg_in = 1'b1;
         end
      end

      // end of text: flush what is open, then back to reset values
      if (end_of_text) begin
         if (mode_in == MODE_NAME || mode_in == MODE_GAP) begin
            res_v = add_res(res_v, KIND_DISCARD, 8'd0, OUT_LINE_BITS'(cmd_line_in));
         end else if (mode_in == MODE_LIST || mode_in == MODE_LIST_COMMENT) begin
            if (arg_in)
               res_v = add_res(res_v, KIND_ARG_END, 8'd0, OUT_LINE_BITS'(cmd_line_in));
            res_v = add_res(res_v, KIND_CMD_END, 8'd0, OUT_LINE_BITS'(cmd_line_in));
         end
         mode_in     = MODE_TOP;
         quote_in    = 1'b0;
         esc_in      = 1'b0;
         arg_in      = 1'b0;
         depth_in    = '0;
         cur_line_in = LINE_ONE;
         cmd_line_in = LINE_ONE;
      end
   end

   assign bundle = res_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_TOP;
         quote_ff    <= 1'b0;
         esc_ff      <= 1'b0;
         arg_ff      <= 1'b0;
         depth_ff    <= '0;
         cur_line_ff <= LINE_ONE;
         cmd_line_ff <= LINE_ONE;
      end else if (accept) begin
         mode_ff     <= mode_in;
         quote_ff    <= quote_in;
         esc_ff      <= esc_in;
         arg_ff      <= arg_in;
         depth_ff    <= depth_in;
         cur_line_ff <= cur_line_in;
         cmd_line_ff <= cmd_line_in;
      end
   end

endmodule

FILE: src/bcl_queue.sv
`timescale 1ns / 1ps

module bcl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bcl_pkg::bundle_type push_bundle,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output bcl_pkg::bundle_type head_bundle
);
   import bcl_pkg::*;

   bundle_type              entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0]       count_ff, count_in;

   assign full        = count_ff == (PTR_BITS+1)'(QUEUE_DEPTH);
   assign head_valid  = count_ff != '0;
   assign head_bundle = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_bundle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");

   a_fill_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("fill count out of step");

endmodule

FILE: src/bcl_back.sv
`timescale 1ns / 1ps

module bcl_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  bcl_pkg::bundle_type head_bundle,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_token_kind,
   output logic [7:0]          rsp_token_char,
   output logic [23:0]         rsp_line_number,
   output logic                rsp_last_of_run
);
   import bcl_pkg::*;

   logic [CNT_BITS-1:0]       sub_ff;
   logic                      valid_ff;
   logic [2:0]                kind_ff;
   logic [7:0]                char_ff;
   logic [OUT_LINE_BITS-1:0]  line_ff;
   logic                      last_ff;
   logic                      load, last;

   assign load = head_valid && (!valid_ff || !rsp_stall);
   assign last = sub_ff == head_bundle.count - 1'b1;
   assign pop  = load && last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            sub_ff   <= last ? '0 : sub_ff + 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= head_bundle.res[sub_ff].kind;
         char_ff <= head_bundle.res[sub_ff].ch;
         line_ff <= head_bundle.res[sub_ff].line;
         last_ff <= last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_token_kind  = kind_ff;
   assign rsp_token_char  = char_ff;
   assign rsp_line_number = line_ff;
   assign rsp_last_of_run = last_ff;

   a_sub_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> sub_ff < head_bundle.count)
      else $error("result index past end of word");

   a_sub_idle: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> sub_ff == '0)
      else $error("result index left open with empty queue");

endmodule

FILE: src/build_script_command_lexer_unit.sv
// Build-script command lexer.
// Input channel req_*: one text byte per word, req_end_of_text on the last byte
// of a text. A word is taken when req_valid is high and req_stall is low.
// Result channel rsp_*: token kind, character, line of the command name and
// rsp_last_of_run on the final result of each input byte; a byte yields zero to
// three results. A result is taken when rsp_valid is high and rsp_stall low.
// A byte's first result passes through the queue and then the output register
// before rsp_valid rises for it.
// Throughput: one byte per cycle while each byte yields at most one result and
// rsp_stall stays low; the output side moves one result per cycle unless
// stalled, each result of a byte in turn. A four-entry queue between the lexer
// and the output register absorbs bursts; req_stall rises only when that queue
// is full. When the receiver stalls, the current result holds and the queue fills.
// Reset (synchronous) empties the queue and returns the lexer to top level,
// line 1. End of text closes any open argument and command and resets the
// lexer state so the next byte begins a new text.
`timescale 1ns / 1ps

module build_script_command_lexer_unit #(
   parameter int MAX_NESTING = bcl_pkg::MAX_NESTING_DEF,
   parameter int LINE_BITS   = bcl_pkg::LINE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_token_kind,
   output logic [7:0]  rsp_token_char,
   output logic [23:0] rsp_line_number,
   output logic        rsp_last_of_run
);
   import bcl_pkg::*;

   logic       accept, push, full, pop, head_valid;
   bundle_type bundle, head_bundle;

   assign req_stall = full;
   assign accept    = req_valid && !full;
   assign push      = accept && (bundle.count != '0);

   bcl_front #(
      .MAX_NESTING (MAX_NESTING),
      .LINE_BITS   (LINE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .bundle      (bundle)
   );

   bcl_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (bundle),
      .full        (full),
      .pop         (pop),
      .head_valid  (head_valid),
      .head_bundle (head_bundle)
   );

   bcl_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_bundle     (head_bundle),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_token_char  (rsp_token_char),
      .rsp_line_number (rsp_line_number),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
